FILE: rtl/seven_segment_serial_display_driver_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the seven-segment serial display driver
// Concurrent checks that compile away when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_SERIAL_DISPLAY_DRIVER_DEFINES_SVH
`define SEVEN_SEGMENT_SERIAL_DISPLAY_DRIVER_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define SSD_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed in %m");
// next-cycle implication
`define SSD_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed in %m");
`else
`define SSD_ASSERT_IMP(lbl, clk, rst_n, pre, post)
`define SSD_ASSERT_NXT(lbl, clk, rst_n, pre, post)
`endif

`endif

FILE: rtl/ssd_pkg.sv
// ---------------------------------------------------------------------------
// ssd_pkg
// Shared types, codes and the segment table of the serial display driver.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ssd_pkg;

    // command opcodes
    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_RAW    = 3'd1;
    localparam logic [2:0] OP_HEXDIG = 3'd2;
    localparam logic [2:0] OP_DEC    = 3'd3;
    localparam logic [2:0] OP_HEX    = 3'd4;
    localparam logic [2:0] OP_BRIGHT = 3'd5;
    localparam logic [2:0] OP_COLON  = 3'd6;

    // configuration register indexes
    localparam logic [2:0] CFG_DATA_CMD   = 3'd0;
    localparam logic [2:0] CFG_ADDR_CMD   = 3'd1;
    localparam logic [2:0] CFG_CTRL_BASE  = 3'd2;
    localparam logic [2:0] CFG_DEF_BRIGHT = 3'd3;
    localparam logic [2:0] CFG_START_HOLD = 3'd4;
    localparam logic [2:0] CFG_HALF_BIT   = 3'd5;

    // configuration reset values
    localparam logic [7:0] RST_DATA_CMD   = 8'h40;
    localparam logic [7:0] RST_ADDR_CMD   = 8'hC0;
    localparam logic [7:0] RST_CTRL_BASE  = 8'h87;
    localparam logic [3:0] RST_DEF_BRIGHT = 4'd4;
    localparam logic [7:0] RST_START_HOLD = 8'd5;
    localparam logic [7:0] RST_HALF_BIT   = 8'd10;

    localparam logic [15:0] MAX_BRIGHT = 16'd8;
    localparam logic [4:0]  SEG_BLANK  = 5'd16;
    localparam logic [7:0]  SEG_DP     = 8'h80;

    // x / 10 == (x * 0xCCCD) >> 19 for every 16-bit x
    localparam logic [15:0] DEC_RECIP = 16'hCCCD;
    localparam int          DEC_SHIFT = 19;

    typedef enum logic [3:0] {
        PH_IDLE = 4'd0,
        PH_HOLD = 4'd1,
        PH_SLOW = 4'd2,
        PH_BLO  = 4'd3,
        PH_BHI  = 4'd4,
        PH_ALO  = 4'd5,
        PH_AHI  = 4'd6,
        PH_PCLO = 4'd7,
        PH_PDLO = 4'd8,
        PH_PCHI = 4'd9
    } ssd_phase_t;

    typedef struct packed {
        logic [7:0] data_command;
        logic [7:0] address_command;
        logic [7:0] display_control_base;
        logic [3:0] default_brightness;
        logic [7:0] start_hold_ticks;
        logic [7:0] half_bit_ticks;
    } ssd_cfg_t;

    // front to back: what the accepted item asks of the sequencer
    typedef struct packed {
        logic tick;
        logic start;
    } ssd_ctl_t;

    // one queue entry
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } ssd_qword_t;

    // levels after the current item
    typedef struct packed {
        logic clock_pin;
        logic data_pin;
        logic busy;
    } ssd_pins_t;

    function automatic logic [7:0] seg_of(input logic [4:0] d);
        logic [7:0] s;
        case (d)
            5'd0:    s = 8'h3F;
            5'd1:    s = 8'h06;
            5'd2:    s = 8'h5B;
            5'd3:    s = 8'h4F;
            5'd4:    s = 8'h66;
            5'd5:    s = 8'h6D;
            5'd6:    s = 8'h7D;
            5'd7:    s = 8'h07;
            5'd8:    s = 8'h7F;
            5'd9:    s = 8'h6F;
            5'd10:   s = 8'h77;
            5'd11:   s = 8'h7C;
            5'd12:   s = 8'h39;
            5'd13:   s = 8'h5E;
            5'd14:   s = 8'h79;
            5'd15:   s = 8'h71;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/ssd_cmd_if.sv
// ---------------------------------------------------------------------------
// ssd_cmd_if
// Command channel: valid/ready with opcode, value, position and flag.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ssd_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [15:0] value;
    logic [2:0]  position;
    logic        flag;

    modport source (output valid, output opcode, output value, output position,
                    output flag, input ready);
    modport sink   (input valid, input opcode, input value, input position,
                    input flag, output ready);
endinterface

`default_nettype wire

FILE: rtl/ssd_res_if.sv
// ---------------------------------------------------------------------------
// ssd_res_if
// Result channel: valid/ready with pin levels, busy and accepted flags.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ssd_res_if;
    logic valid;
    logic ready;
    logic clock_pin;
    logic data_pin;
    logic busy_res;
    logic accepted;

    modport source (output valid, output clock_pin, output data_pin,
                    output busy_res, output accepted, input ready);
    modport sink   (input valid, input clock_pin, input data_pin,
                    input busy_res, input accepted, output ready);
endinterface

`default_nettype wire

FILE: rtl/ssd_front.sv
// ---------------------------------------------------------------------------
// ssd_front
// Classifies items, builds the byte queue and runs the decimal digit unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "seven_segment_serial_display_driver_defines.svh"

module ssd_front #(
    parameter int DIGIT_COUNT = 4,
    parameter int QDEPTH      = DIGIT_COUNT + 4,
    parameter int QW          = $clog2(QDEPTH)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [2:0]        opcode,
    input  wire logic [15:0]       value,
    input  wire logic [2:0]        position,
    input  wire logic              flag,
    input  wire ssd_pkg::ssd_cfg_t cfg,
    input  wire logic              idle,
    input  wire logic [QW-1:0]     rd_index,
    output ssd_pkg::ssd_ctl_t      ctl,
    output ssd_pkg::ssd_qword_t    qword,
    output logic [QW-1:0]          byte_count
);

    localparam int DW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT + 1) : 1;

    logic [7:0]    q_data_reg [QDEPTH];
    logic          q_last_reg [QDEPTH];
    logic [QW-1:0] count_reg, count_next;
    logic [7:0]    sdig_reg, sdig_next;

    logic          dec_busy_reg, dec_busy_next;
    logic [DW-1:0] dec_i_reg, dec_i_next;
    logic [15:0]   dec_val_reg, dec_val_next;
    logic          dec_sep_reg, dec_sep_next;

    logic          wr_en   [QDEPTH];
    logic [7:0]    wr_data [QDEPTH];
    logic          wr_last [QDEPTH];

    logic [31:0]   prod;
    logic [12:0]   quot;
    logic [15:0]   ten_q;
    logic [3:0]    rem;
    logic [7:0]    dig_seg;
    logic [QW-1:0] dig_pos;
    logic [31:0]   hex_src;
    logic [7:0]    single_seg;
    logic [7:0]    colon_seg;

    function automatic logic [7:0] bright_cmd(input logic [7:0] base,
                                              input logic [15:0] b);
        logic [15:0] sat;
        sat = (b > ssd_pkg::MAX_BRIGHT) ? ssd_pkg::MAX_BRIGHT : b;
        return base + sat[7:0];
    endfunction

    assign ctl.tick  = accept && (opcode == ssd_pkg::OP_TICK);
    assign ctl.start = accept && (opcode != ssd_pkg::OP_TICK)
                       && (opcode <= ssd_pkg::OP_COLON) && idle;

    assign qword.data = q_data_reg[rd_index];
    assign qword.last = q_last_reg[rd_index];
    assign byte_count = count_reg;

    // one decimal digit per cycle, least significant first
    assign prod    = 32'(dec_val_reg) * 32'(ssd_pkg::DEC_RECIP);
    assign quot    = prod[ssd_pkg::DEC_SHIFT +: 13];
    assign ten_q   = 16'({quot, 3'b000}) + 16'({quot, 1'b0});
    assign rem     = 4'(dec_val_reg - ten_q);
    assign dig_seg = ssd_pkg::seg_of({1'b0, rem})
                     | ((DIGIT_COUNT > 2 && dec_sep_reg && dec_i_reg == DW'(2))
                        ? ssd_pkg::SEG_DP : 8'h00);
    assign dig_pos = QW'(DIGIT_COUNT + 1) - QW'(dec_i_reg);

    assign hex_src    = {16'h0000, value};
    assign single_seg = (opcode == ssd_pkg::OP_RAW) ? value[7:0]
                        : ssd_pkg::seg_of((value > 16'd16) ? ssd_pkg::SEG_BLANK : value[4:0]);
    assign colon_seg  = flag ? (sdig_reg | ssd_pkg::SEG_DP) : sdig_reg;

    always_comb
    begin
        count_next    = count_reg;
        sdig_next     = sdig_reg;
        dec_busy_next = dec_busy_reg;
        dec_i_next    = dec_i_reg;
        dec_val_next  = dec_val_reg;
        dec_sep_next  = dec_sep_reg;
        for (int e = 0; e < QDEPTH; e++)
        begin
            wr_en[e]   = 1'b0;
            wr_data[e] = 8'h00;
            wr_last[e] = 1'b0;
        end

        if (ctl.start)
        begin
            case (opcode)
                ssd_pkg::OP_RAW, ssd_pkg::OP_HEXDIG, ssd_pkg::OP_COLON:
                begin
                    wr_en[0]   = 1'b1;
                    wr_data[0] = cfg.data_command;
                    wr_last[0] = 1'b1;
                    wr_en[1]   = 1'b1;
                    wr_en[2]   = 1'b1;
                    wr_last[2] = 1'b1;
                    count_next = QW'(3);
                    if (opcode == ssd_pkg::OP_COLON)
                    begin
                        wr_data[1] = cfg.address_command + 8'd1;
                        wr_data[2] = colon_seg;
                        sdig_next  = colon_seg;
                    end
                    else
                    begin
                        wr_data[1] = cfg.address_command + {5'b00000, position};
                        wr_data[2] = single_seg;
                        if (position == 3'd1)
                            sdig_next = single_seg;
                    end
                end
                ssd_pkg::OP_DEC, ssd_pkg::OP_HEX:
                begin
                    wr_en[0]   = 1'b1;
                    wr_data[0] = cfg.data_command;
                    wr_last[0] = 1'b1;
                    wr_en[1]   = 1'b1;
                    wr_data[1] = cfg.address_command;
                    if (opcode == ssd_pkg::OP_HEX)
                    begin
                        // digit i (nibble i) sits at entry DIGIT_COUNT+1-i
                        for (int e = 2; e < DIGIT_COUNT + 2; e++)
                        begin
                            wr_en[e]   = 1'b1;
                            wr_data[e] = ssd_pkg::seg_of(
                                {1'b0, hex_src[4 * (DIGIT_COUNT + 1 - e) +: 4]});
                            wr_last[e] = (e == DIGIT_COUNT + 1);
                        end
                        wr_en[DIGIT_COUNT + 2]   = 1'b1;
                        wr_data[DIGIT_COUNT + 2] = bright_cmd(cfg.display_control_base,
                                                              16'(cfg.default_brightness));
                        wr_last[DIGIT_COUNT + 2] = 1'b1;
                        count_next = QW'(DIGIT_COUNT + 3);
                    end
                    else
                    begin
                        dec_busy_next = 1'b1;
                        dec_i_next    = '0;
                        dec_val_next  = value;
                        dec_sep_next  = flag;
                        count_next    = QW'(DIGIT_COUNT + 2);
                    end
                end
                ssd_pkg::OP_BRIGHT:
                begin
                    wr_en[0]   = 1'b1;
                    wr_data[0] = bright_cmd(cfg.display_control_base, value);
                    wr_last[0] = 1'b1;
                    count_next = QW'(1);
                end
                default:
                begin
                end
            endcase
        end

        if (dec_busy_reg)
        begin
            for (int e = 2; e < DIGIT_COUNT + 2; e++)
            begin
                if (dig_pos == QW'(e))
                begin
                    wr_en[e]   = 1'b1;
                    wr_data[e] = dig_seg;
                    wr_last[e] = (dec_i_reg == '0);
                end
            end
            dec_val_next = 16'(quot);
            dec_i_next   = dec_i_reg + DW'(1);
            if (dec_i_reg == DW'(DIGIT_COUNT - 1))
                dec_busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            sdig_reg     <= 8'h00;
            dec_busy_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            sdig_reg     <= sdig_next;
            dec_busy_reg <= dec_busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dec_i_reg   <= dec_i_next;
        dec_val_reg <= dec_val_next;
        dec_sep_reg <= dec_sep_next;
        for (int e = 0; e < QDEPTH; e++)
        begin
            if (wr_en[e])
            begin
                q_data_reg[e] <= wr_data[e];
                q_last_reg[e] <= wr_last[e];
            end
        end
    end

    // digits finish long before the sequencer can go idle again
    `SSD_ASSERT_IMP(a_dec_only_busy, clk, rst_n, dec_busy_reg, !idle)
    `SSD_ASSERT_NXT(a_start_fills, clk, rst_n, ctl.start, count_reg != '0)

endmodule

`default_nettype wire

FILE: rtl/ssd_back.sv
// ---------------------------------------------------------------------------
// ssd_back
// Bus waveform sequencer: plays the byte queue out, pacing phases by ticks.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "seven_segment_serial_display_driver_defines.svh"

module ssd_back #(
    parameter int QW = 3
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ssd_pkg::ssd_ctl_t   ctl,
    input  wire ssd_pkg::ssd_cfg_t   cfg,
    input  wire ssd_pkg::ssd_qword_t qword,
    input  wire logic [QW-1:0]       byte_count,
    output logic [QW-1:0]            rd_index,
    output logic                     idle,
    output ssd_pkg::ssd_pins_t       pins_next
);

    ssd_pkg::ssd_phase_t phase_reg, phase_next, enter_ph;
    logic [QW-1:0] byte_index_reg, byte_index_next;
    logic [2:0]    bit_index_reg, bit_index_next;
    logic [7:0]    wait_count_reg, wait_count_next;
    logic          clock_level_reg, clock_level_next;
    logic          data_level_reg, data_level_next;
    logic [7:0]    cur_byte_reg, cur_byte_next;
    logic          cur_last_reg, cur_last_next;

    logic          do_enter;
    logic          load;
    logic [7:0]    wc_dec;
    logic [7:0]    half_ticks;
    logic [7:0]    hold_ticks;
    logic [QW:0]   index_inc;

    assign half_ticks = (cfg.half_bit_ticks == 8'd0) ? 8'd1 : cfg.half_bit_ticks;
    assign hold_ticks = (cfg.start_hold_ticks == 8'd0) ? 8'd1 : cfg.start_hold_ticks;
    assign wc_dec     = (wait_count_reg != 8'd0) ? wait_count_reg - 8'd1 : 8'd0;
    assign index_inc  = {1'b0, byte_index_reg} + (QW + 1)'(1);
    assign idle       = (phase_reg == ssd_pkg::PH_IDLE);

    always_comb
    begin
        phase_next       = phase_reg;
        byte_index_next  = byte_index_reg;
        bit_index_next   = bit_index_reg;
        wait_count_next  = wait_count_reg;
        clock_level_next = clock_level_reg;
        data_level_next  = data_level_reg;
        enter_ph         = ssd_pkg::PH_IDLE;
        do_enter         = 1'b0;
        load             = 1'b0;
        rd_index         = byte_index_reg;

        if (ctl.start)
        begin
            byte_index_next = '0;
            bit_index_next  = 3'd0;
            enter_ph        = ssd_pkg::PH_HOLD;
            do_enter        = 1'b1;
        end
        else if (ctl.tick && !idle)
        begin
            if (wc_dec != 8'd0)
                wait_count_next = wc_dec;
            else
            begin
                do_enter = 1'b1;
                case (phase_reg)
                    ssd_pkg::PH_HOLD: enter_ph = ssd_pkg::PH_SLOW;
                    ssd_pkg::PH_SLOW:
                    begin
                        bit_index_next = 3'd0;
                        load           = 1'b1;
                        enter_ph       = ssd_pkg::PH_BLO;
                    end
                    ssd_pkg::PH_BLO: enter_ph = ssd_pkg::PH_BHI;
                    ssd_pkg::PH_BHI:
                    begin
                        if (bit_index_reg != 3'd7)
                        begin
                            bit_index_next = bit_index_reg + 3'd1;
                            enter_ph       = ssd_pkg::PH_BLO;
                        end
                        else
                            enter_ph = ssd_pkg::PH_ALO;
                    end
                    ssd_pkg::PH_ALO: enter_ph = ssd_pkg::PH_AHI;
                    ssd_pkg::PH_AHI:
                    begin
                        if (cur_last_reg)
                            enter_ph = ssd_pkg::PH_PCLO;
                        else
                        begin
                            // next byte of the same transaction
                            byte_index_next = index_inc[QW-1:0];
                            rd_index        = index_inc[QW-1:0];
                            bit_index_next  = 3'd0;
                            load            = 1'b1;
                            enter_ph        = ssd_pkg::PH_BLO;
                        end
                    end
                    ssd_pkg::PH_PCLO: enter_ph = ssd_pkg::PH_PDLO;
                    ssd_pkg::PH_PDLO: enter_ph = ssd_pkg::PH_PCHI;
                    ssd_pkg::PH_PCHI:
                    begin
                        bit_index_next = 3'd0;
                        if (index_inc < {1'b0, byte_count})
                        begin
                            byte_index_next = index_inc[QW-1:0];
                            enter_ph        = ssd_pkg::PH_HOLD;
                        end
                        else
                        begin
                            byte_index_next = '0;
                            enter_ph        = ssd_pkg::PH_IDLE;
                        end
                    end
                    default: enter_ph = ssd_pkg::PH_IDLE;
                endcase
            end
        end

        cur_byte_next = load ? qword.data : cur_byte_reg;
        cur_last_next = load ? qword.last : cur_last_reg;

        if (do_enter)
        begin
            phase_next      = enter_ph;
            wait_count_next = half_ticks;
            case (enter_ph)
                ssd_pkg::PH_HOLD:
                begin
                    clock_level_next = 1'b1;
                    data_level_next  = 1'b1;
                    wait_count_next  = hold_ticks;
                end
                ssd_pkg::PH_SLOW:
                begin
                    clock_level_next = 1'b1;
                    data_level_next  = 1'b0;
                    wait_count_next  = 8'd1;
                end
                ssd_pkg::PH_BLO:
                begin
                    clock_level_next = 1'b0;
                    data_level_next  = cur_byte_next[bit_index_next];
                end
                ssd_pkg::PH_BHI:
                begin
                    clock_level_next = 1'b1;
                    data_level_next  = cur_byte_next[bit_index_next];
                end
                ssd_pkg::PH_ALO:  clock_level_next = 1'b0;
                ssd_pkg::PH_AHI:  clock_level_next = 1'b1;
                ssd_pkg::PH_PCLO: clock_level_next = 1'b0;
                ssd_pkg::PH_PDLO:
                begin
                    clock_level_next = 1'b0;
                    data_level_next  = 1'b0;
                end
                ssd_pkg::PH_PCHI:
                begin
                    clock_level_next = 1'b1;
                    data_level_next  = 1'b0;
                end
                default:
                begin
                    phase_next       = ssd_pkg::PH_IDLE;
                    clock_level_next = 1'b1;
                    data_level_next  = 1'b1;
                    wait_count_next  = 8'd0;
                end
            endcase
        end

        pins_next.clock_pin = clock_level_next;
        pins_next.data_pin  = data_level_next;
        pins_next.busy      = (phase_next != ssd_pkg::PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= ssd_pkg::PH_IDLE;
            byte_index_reg  <= '0;
            bit_index_reg   <= 3'd0;
            wait_count_reg  <= 8'd0;
            clock_level_reg <= 1'b1;
            data_level_reg  <= 1'b1;
        end
        else
        begin
            phase_reg       <= phase_next;
            byte_index_reg  <= byte_index_next;
            bit_index_reg   <= bit_index_next;
            wait_count_reg  <= wait_count_next;
            clock_level_reg <= clock_level_next;
            data_level_reg  <= data_level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_byte_reg <= cur_byte_next;
        cur_last_reg <= cur_last_next;
    end

    `SSD_ASSERT_IMP(a_start_when_idle, clk, rst_n, ctl.start, idle)
    `SSD_ASSERT_IMP(a_idle_lines_high, clk, rst_n, idle,
                    clock_level_reg && data_level_reg && wait_count_reg == 8'd0)
    `SSD_ASSERT_IMP(a_wait_nonzero, clk, rst_n, !idle, wait_count_reg != 8'd0)

endmodule

`default_nettype wire

FILE: rtl/seven_segment_serial_display_driver.sv
// ---------------------------------------------------------------------------
// seven_segment_serial_display_driver
// Two-wire serial driver for a four-digit seven-segment display.
// ---------------------------------------------------------------------------
// Usage:
//   cmd carries one item per handshake: opcode 0 is a time tick, 1..6 are
//   display commands (raw segments, hex digit, decimal, hex, brightness,
//   colon). Every item gives exactly one result item on res: the clock and
//   data pin levels after that item, busy, and whether a command was taken.
//   A command is taken only when no transaction is in flight.
//   One item per cycle while res is not stalled; the result is registered
//   and shows up in the cycle after the item is accepted. The sequencer
//   steps a phase once its count of tick items runs out, so the waveform
//   is timed by the tick stream. A decimal command converts its digits
//   after it is taken, one digit per cycle through the reciprocal multiplier.
//   cmd.ready stays high while the result register is empty or being
//   taken; a stalled res holds its item and drops cmd.ready until taken.
//   Reset: idle with both pins high, registers at their defaults.
//   Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module seven_segment_serial_display_driver #(
    parameter int DIGIT_COUNT = 4
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ssd_cmd_if.sink    cmd,
    ssd_res_if.source  res,
    input  wire logic       cfg_we,
    input  wire logic [2:0] cfg_index,
    input  wire logic [7:0] cfg_data
);

    localparam int QDEPTH = DIGIT_COUNT + 4;
    localparam int QW     = $clog2(QDEPTH);

    ssd_pkg::ssd_cfg_t   cfg_reg;
    ssd_pkg::ssd_ctl_t   ctl;
    ssd_pkg::ssd_qword_t qword;
    ssd_pkg::ssd_pins_t  pins_next;
    logic [QW-1:0]       rd_index;
    logic [QW-1:0]       byte_count;
    logic                idle;
    logic                in_ready;
    logic                accept;

    logic res_valid_reg;
    logic clock_pin_reg, data_pin_reg, busy_reg, accepted_reg;

    assign in_ready  = !res_valid_reg || res.ready;
    assign accept    = cmd.valid && in_ready;
    assign cmd.ready = in_ready;

    assign res.valid     = res_valid_reg;
    assign res.clock_pin = clock_pin_reg;
    assign res.data_pin  = data_pin_reg;
    assign res.busy_res  = busy_reg;
    assign res.accepted  = accepted_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.data_command         <= ssd_pkg::RST_DATA_CMD;
            cfg_reg.address_command      <= ssd_pkg::RST_ADDR_CMD;
            cfg_reg.display_control_base <= ssd_pkg::RST_CTRL_BASE;
            cfg_reg.default_brightness   <= ssd_pkg::RST_DEF_BRIGHT;
            cfg_reg.start_hold_ticks     <= ssd_pkg::RST_START_HOLD;
            cfg_reg.half_bit_ticks       <= ssd_pkg::RST_HALF_BIT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ssd_pkg::CFG_DATA_CMD:   cfg_reg.data_command         <= cfg_data;
                ssd_pkg::CFG_ADDR_CMD:   cfg_reg.address_command      <= cfg_data;
                ssd_pkg::CFG_CTRL_BASE:  cfg_reg.display_control_base <= cfg_data;
                ssd_pkg::CFG_DEF_BRIGHT: cfg_reg.default_brightness   <= cfg_data[3:0];
                ssd_pkg::CFG_START_HOLD: cfg_reg.start_hold_ticks     <= cfg_data;
                ssd_pkg::CFG_HALF_BIT:   cfg_reg.half_bit_ticks       <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (accept)
            res_valid_reg <= 1'b1;
        else if (res.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            clock_pin_reg <= pins_next.clock_pin;
            data_pin_reg  <= pins_next.data_pin;
            busy_reg      <= pins_next.busy;
            accepted_reg  <= ctl.start;
        end
    end

    ssd_front #(
        .DIGIT_COUNT (DIGIT_COUNT),
        .QDEPTH      (QDEPTH),
        .QW          (QW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .opcode     (cmd.opcode),
        .value      (cmd.value),
        .position   (cmd.position),
        .flag       (cmd.flag),
        .cfg        (cfg_reg),
        .idle       (idle),
        .rd_index   (rd_index),
        .ctl        (ctl),
        .qword      (qword),
        .byte_count (byte_count)
    );

    ssd_back #(
        .QW (QW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .cfg        (cfg_reg),
        .qword      (qword),
        .byte_count (byte_count),
        .rd_index   (rd_index),
        .idle       (idle),
        .pins_next  (pins_next)
    );

endmodule

`default_nettype wire

FILE: tb/tb_seven_segment_serial_display_driver.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_seven_segment_serial_display_driver
// Self-checking bench for the two-wire seven-segment display driver. Every
// item sent on cmd is run through a local model of the bus sequencer, and
// each item on res is compared field by field with the oldest predicted
// pin state. Directed commands come first, then register extremes, output
// back-pressure and random rounds under changing register settings.
// ---------------------------------------------------------------------------

module tb_seven_segment_serial_display_driver;
    import ssd_pkg::*;

    localparam int DIGIT_COUNT      = 4;
    localparam int QDEPTH           = DIGIT_COUNT + 4;
    localparam int SETTLE_CYCLES    = DIGIT_COUNT + 8;
    localparam int HOLD_OFF_CYCLES  = 300;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int ROUND_ITEMS      = 75;
    localparam int RANDOM_ITEMS     = 150;
    localparam int RANDOM_COMMANDS  = 6;
    localparam logic [2:0] OP_UNUSED = 3'd7;

    typedef struct packed {
        logic clock_pin;
        logic data_pin;
        logic busy;
        logic accepted;
    } pin_levels_t;

    logic clk;
    logic rst_n;
    logic       cfg_we;
    logic [2:0] cfg_index;
    logic [7:0] cfg_data;

    ssd_cmd_if cmd_ch();
    ssd_res_if res_ch();

    seven_segment_serial_display_driver #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // bus sequencer model
    ssd_phase_t  seq_phase;
    logic [7:0]  byte_fifo [QDEPTH];
    logic        byte_last [QDEPTH];
    int          byte_total;
    int          byte_pos;
    int          bit_pos;
    int          wait_left;
    logic        clk_lvl;
    logic        dat_lvl;
    logic [7:0]  digit2_segs;
    ssd_cfg_t    cfg_shadow;

    pin_levels_t pending_levels[$];

    int errors;
    int items_sent;
    int cmds_taken;
    int results_checked;
    int gap_pct;
    int stall_pct;
    int hold_asks;
    int hold_done;
    int quiet_cycles;

    function automatic logic [7:0] digit_glyph(input int d);
        logic [7:0] g;
        case (d)
            0: g = 8'h3F;   1: g = 8'h06;   2: g = 8'h5B;   3: g = 8'h4F;
            4: g = 8'h66;   5: g = 8'h6D;   6: g = 8'h7D;   7: g = 8'h07;
            8: g = 8'h7F;   9: g = 8'h6F;   10: g = 8'h77;  11: g = 8'h7C;
            12: g = 8'h39;  13: g = 8'h5E;  14: g = 8'h79;  15: g = 8'h71;
            default: g = 8'h00;
        endcase
        return g;
    endfunction

    function automatic int ticks_or_one(input logic [7:0] r);
        return (r == 8'd0) ? 1 : int'(r);
    endfunction

    function automatic void enter_phase(input ssd_phase_t ph);
        logic [7:0] cur;
        logic       b;
        cur = (byte_pos < QDEPTH) ? byte_fifo[byte_pos] : 8'h00;
        b = cur[bit_pos & 7];
        seq_phase = ph;
        wait_left = ticks_or_one(cfg_shadow.half_bit_ticks);
        case (ph)
            PH_HOLD:
            begin
                clk_lvl = 1'b1;
                dat_lvl = 1'b1;
                wait_left = ticks_or_one(cfg_shadow.start_hold_ticks);
            end
            PH_SLOW:
            begin
                clk_lvl = 1'b1;
                dat_lvl = 1'b0;
                wait_left = 1;
            end
            PH_BLO:
            begin
                clk_lvl = 1'b0;
                dat_lvl = b;
            end
            PH_BHI:
            begin
                clk_lvl = 1'b1;
                dat_lvl = b;
            end
            PH_ALO, PH_PCLO: clk_lvl = 1'b0;
            PH_AHI: clk_lvl = 1'b1;
            PH_PDLO:
            begin
                clk_lvl = 1'b0;
                dat_lvl = 1'b0;
            end
            PH_PCHI:
            begin
                clk_lvl = 1'b1;
                dat_lvl = 1'b0;
            end
            default:
            begin
                seq_phase = PH_IDLE;
                clk_lvl = 1'b1;
                dat_lvl = 1'b1;
                wait_left = 0;
            end
        endcase
    endfunction

    function automatic void advance_phase();
        case (seq_phase)
            PH_HOLD: enter_phase(PH_SLOW);
            PH_SLOW:
            begin
                bit_pos = 0;
                enter_phase(PH_BLO);
            end
            PH_BLO: enter_phase(PH_BHI);
            PH_BHI:
            begin
                if (bit_pos < 7)
                begin
                    bit_pos++;
                    enter_phase(PH_BLO);
                end
                else enter_phase(PH_ALO);
            end
            PH_ALO: enter_phase(PH_AHI);
            PH_AHI:
            begin
                // last byte of a transaction goes to stop, else next byte
                if (byte_pos >= QDEPTH || byte_last[byte_pos]) enter_phase(PH_PCLO);
                else
                begin
                    byte_pos++;
                    bit_pos = 0;
                    enter_phase(PH_BLO);
                end
            end
            PH_PCLO: enter_phase(PH_PDLO);
            PH_PDLO: enter_phase(PH_PCHI);
            PH_PCHI:
            begin
                byte_pos++;
                bit_pos = 0;
                if (byte_pos < byte_total && byte_pos < QDEPTH) enter_phase(PH_HOLD);
                else
                begin
                    byte_pos = 0;
                    byte_total = 0;
                    enter_phase(PH_IDLE);
                end
            end
            default: enter_phase(PH_IDLE);
        endcase
    endfunction

    function automatic void push_byte(input logic [7:0] b, input logic last);
        if (byte_total < QDEPTH)
        begin
            byte_fifo[byte_total] = b;
            byte_last[byte_total] = last;
            byte_total++;
        end
    endfunction

    function automatic void push_brightness(input logic [15:0] level);
        logic [7:0] code;
        if (level > MAX_BRIGHT) level = MAX_BRIGHT;
        code = cfg_shadow.display_control_base + level[7:0];
        push_byte(code, 1'b1);
    endfunction

    function automatic void push_single(input logic [2:0] pos, input logic [7:0] segs);
        logic [7:0] addr;
        addr = cfg_shadow.address_command + {5'd0, pos};
        push_byte(cfg_shadow.data_command, 1'b1);
        push_byte(addr, 1'b0);
        push_byte(segs, 1'b1);
    endfunction

    function automatic void reset_predictor();
        cfg_shadow.data_command         = RST_DATA_CMD;
        cfg_shadow.address_command      = RST_ADDR_CMD;
        cfg_shadow.display_control_base = RST_CTRL_BASE;
        cfg_shadow.default_brightness   = RST_DEF_BRIGHT;
        cfg_shadow.start_hold_ticks     = RST_START_HOLD;
        cfg_shadow.half_bit_ticks       = RST_HALF_BIT;
        for (int i = 0; i < QDEPTH; i++)
        begin
            byte_fifo[i] = 8'h00;
            byte_last[i] = 1'b0;
        end
        byte_total = 0;
        byte_pos = 0;
        bit_pos = 0;
        digit2_segs = 8'h00;
        enter_phase(PH_IDLE);
    endfunction

    function automatic pin_levels_t predict_levels(input logic [2:0] op,
            input logic [15:0] val, input logic [2:0] pos, input logic flag);
        pin_levels_t lv;
        logic [7:0]  segs;
        logic [15:0] num;
        logic [7:0]  digs [DIGIT_COUNT];
        lv.accepted = 1'b0;
        if (op == OP_TICK)
        begin
            if (seq_phase != PH_IDLE)
            begin
                if (wait_left > 0) wait_left--;
                if (wait_left == 0) advance_phase();
            end
        end
        else if (op != OP_UNUSED && seq_phase == PH_IDLE)
        begin
            lv.accepted = 1'b1;
            byte_total = 0;
            byte_pos = 0;
            bit_pos = 0;
            case (op)
                OP_RAW, OP_HEXDIG:
                begin
                    segs = (op == OP_RAW) ? val[7:0]
                                          : digit_glyph((val > 16'd16) ? 16 : int'(val));
                    if (pos == 3'd1) digit2_segs = segs;
                    push_single(pos, segs);
                end
                OP_DEC, OP_HEX:
                begin
                    num = val;
                    for (int i = 0; i < DIGIT_COUNT; i++)
                    begin
                        if (op == OP_DEC)
                        begin
                            digs[i] = digit_glyph(int'(num % 16'd10));
                            if (i == 2 && flag) digs[i] |= SEG_DP;
                            num = num / 16'd10;
                        end
                        else digs[i] = digit_glyph(int'((val >> (4 * i)) & 16'hF));
                    end
                    push_byte(cfg_shadow.data_command, 1'b1);
                    push_byte(cfg_shadow.address_command, 1'b0);
                    for (int i = DIGIT_COUNT - 1; i >= 0; i--) push_byte(digs[i], i == 0);
                    if (op == OP_HEX) push_brightness({12'd0, cfg_shadow.default_brightness});
                end
                OP_BRIGHT: push_brightness(val);
                default:
                begin
                    // colon: OR the point onto the remembered second digit
                    if (flag) digit2_segs |= SEG_DP;
                    push_single(3'd1, digit2_segs);
                end
            endcase
            enter_phase(PH_HOLD);
        end
        lv.clock_pin = clk_lvl;
        lv.data_pin = dat_lvl;
        lv.busy = (seq_phase != PH_IDLE);
        return lv;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int idle_length(input int pct);
        if (pct == 0 || $urandom_range(99) >= pct) return 0;
        if ($urandom_range(19) == 0) return $urandom_range(40, 10);
        return $urandom_range(3, 1);
    endfunction

    function automatic ssd_cfg_t make_cfg(input logic [7:0] dc, input logic [7:0] ac,
            input logic [7:0] base, input logic [3:0] br, input logic [7:0] hold,
            input logic [7:0] half);
        ssd_cfg_t c;
        c.data_command = dc;
        c.address_command = ac;
        c.display_control_base = base;
        c.default_brightness = br;
        c.start_hold_ticks = hold;
        c.half_bit_ticks = half;
        return c;
    endfunction

    task automatic send_item(input logic [2:0] op, input logic [15:0] val,
            input logic [2:0] pos, input logic flag);
        int          gap;
        pin_levels_t lv;
        gap = idle_length(gap_pct);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.opcode <= op;
        cmd_ch.value <= val;
        cmd_ch.position <= pos;
        cmd_ch.flag <= flag;
        do @(posedge clk); while (!cmd_ch.ready);
        lv = predict_levels(op, val, pos, flag);
        pending_levels.push_back(lv);
        items_sent++;
        if (lv.accepted) cmds_taken++;
    endtask

    task automatic send_tick();
        send_item(OP_TICK, 16'($urandom), 3'($urandom), 1'($urandom));
    endtask

    task automatic run_until_idle();
        while (seq_phase != PH_IDLE) send_tick();
    endtask

    task automatic do_command(input logic [2:0] op, input logic [15:0] val,
            input logic [2:0] pos, input logic flag);
        send_item(op, val, pos, flag);
        run_until_idle();
    endtask

    task automatic pause_sender();
        cmd_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_levels.size() != 0);
    endtask

    task automatic put_register(input logic [2:0] idx, input logic [7:0] d);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
    endtask

    // registers change only with the sequencer idle and every result back
    task automatic write_config(input ssd_cfg_t c);
        run_until_idle();
        pause_sender();
        repeat (SETTLE_CYCLES) @(posedge clk);
        put_register(CFG_DATA_CMD, c.data_command);
        put_register(CFG_ADDR_CMD, c.address_command);
        put_register(CFG_CTRL_BASE, c.display_control_base);
        put_register(CFG_DEF_BRIGHT, {4'd0, c.default_brightness});
        put_register(CFG_START_HOLD, c.start_hold_ticks);
        put_register(CFG_HALF_BIT, c.half_bit_ticks);
        cfg_we <= 1'b0;
        cfg_shadow = c;
    endtask

    // timing only, the byte codes keep their current values
    task automatic write_timing(input logic [7:0] hold, input logic [7:0] half);
        run_until_idle();
        pause_sender();
        repeat (SETTLE_CYCLES) @(posedge clk);
        put_register(CFG_START_HOLD, hold);
        put_register(CFG_HALF_BIT, half);
        cfg_we <= 1'b0;
        cfg_shadow.start_hold_ticks = hold;
        cfg_shadow.half_bit_ticks = half;
    endtask

    task automatic send_random_command();
        logic [2:0]  op;
        logic [15:0] val;
        op = 3'($urandom_range(6, 1));
        val = 16'($urandom);
        case (op)
            OP_HEXDIG, OP_BRIGHT: if ($urandom_range(1)) val = 16'($urandom_range(17));
            OP_DEC: if ($urandom_range(1)) val = 16'($urandom_range(9999));
            default: ;
        endcase
        send_item(op, val, 3'($urandom), 1'($urandom));
    endtask

    task automatic check_levels();
        pin_levels_t got;
        pin_levels_t want;
        got.clock_pin = res_ch.clock_pin;
        got.data_pin = res_ch.data_pin;
        got.busy = res_ch.busy_res;
        got.accepted = res_ch.accepted;
        results_checked++;
        if (pending_levels.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected result item clk=%b dat=%b busy=%b acc=%b", $time,
                     got.clock_pin, got.data_pin, got.busy, got.accepted);
            return;
        end
        want = pending_levels.pop_front();
        if (got.clock_pin !== want.clock_pin || got.data_pin !== want.data_pin ||
            got.busy !== want.busy || got.accepted !== want.accepted)
        begin
            errors++;
            $display("%0t: mismatch expected clk=%b dat=%b busy=%b acc=%b,", $time,
                     want.clock_pin, want.data_pin, want.busy, want.accepted);
            $display("%0t:          got clk=%b dat=%b busy=%b acc=%b", $time,
                     got.clock_pin, got.data_pin, got.busy, got.accepted);
        end
    endtask

    // result sink with random stalls and requested long hold-offs
    initial
    begin
        int stall_left;
        stall_left = 0;
        hold_done = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_ch.valid && res_ch.ready) check_levels();
            if (stall_left == 0 && hold_done != hold_asks)
            begin
                hold_done = hold_asks;
                stall_left = HOLD_OFF_CYCLES;
            end
            else if (stall_left == 0) stall_left = idle_length(stall_pct);
            if (stall_left > 0)
            begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end
            else res_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic test_reset_values();
        // reset timing and reset brightness base
        do_command(OP_BRIGHT, 16'd2, 3'd0, 1'b0);
    endtask

    task automatic test_commands();
        write_timing(8'd1, 8'd1);
        // command and unused opcode offered while a transaction is running
        send_item(OP_RAW, 16'h0000, 3'd1, 1'b0);
        send_item(OP_DEC, 16'h1234, 3'd0, 1'b1);
        send_item(OP_UNUSED, 16'hFFFF, 3'd7, 1'b1);
        run_until_idle();
        do_command(OP_UNUSED, 16'h0000, 3'd0, 1'b0);
        do_command(OP_HEXDIG, 16'd16, 3'd7, 1'b0);
        do_command(OP_DEC, 16'hFFFF, 3'd0, 1'b1);
        do_command(OP_HEX, 16'hA5C3, 3'd0, 1'b0);
        do_command(OP_BRIGHT, 16'hFFFF, 3'd0, 1'b0);
        do_command(OP_COLON, 16'h0000, 3'd0, 1'b1);
    endtask

    task automatic test_register_extremes();
        write_config(make_cfg(8'h00, 8'h00, 8'h00, 4'd15, 8'd0, 8'd0));
        do_command(OP_RAW, 16'h00AA, 3'd3, 1'b0);
        do_command(OP_HEX, 16'h5A3C, 3'd0, 1'b0);
        // address wraps past 0xFF, brightness code tops out at 0xFF
        write_config(make_cfg(8'hFF, 8'hFF, 8'd247, 4'd8, 8'd1, 8'd1));
        do_command(OP_RAW, 16'h5A5A, 3'd5, 1'b0);
        do_command(OP_BRIGHT, 16'hFFFF, 3'd0, 1'b0);
    endtask

    task automatic test_backpressure();
        write_config(make_cfg(RST_DATA_CMD, RST_ADDR_CMD, RST_CTRL_BASE, RST_DEF_BRIGHT,
                              8'd1, 8'd1));
        gap_pct = 0;
        send_item(OP_HEX, 16'hBEEF, 3'd0, 1'b0);
        hold_asks <= hold_asks + 1;
        repeat (40) send_tick();
        run_until_idle();
        pause_sender();
        do_command(OP_BRIGHT, 16'd7, 3'd0, 1'b1);
    endtask

    task automatic test_random();
        int start_items;
        int start_taken;
        int r;
        int lim_cmd;
        int lim_unused;
        ssd_cfg_t c;
        start_items = items_sent;
        start_taken = cmds_taken;
        while (items_sent - start_items < RANDOM_ITEMS ||
               cmds_taken - start_taken < RANDOM_COMMANDS)
        begin
            c = make_cfg(8'($urandom), 8'($urandom), 8'($urandom_range(247)),
                         4'($urandom_range(8)), 8'($urandom_range(3)),
                         8'($urandom_range(2)));
            if ($urandom_range(3) == 0) c.half_bit_ticks = 8'($urandom_range(4, 3));
            write_config(c);
            gap_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(40, 5);
            stall_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(40, 5);
            for (int n = 0; n < ROUND_ITEMS; n++)
            begin
                r = $urandom_range(99);
                lim_cmd = (seq_phase == PH_IDLE) ? 72 : 5;
                lim_unused = lim_cmd + ((seq_phase == PH_IDLE) ? 5 : 3);
                if (r < lim_cmd) send_random_command();
                else if (r < lim_unused)
                    send_item(OP_UNUSED, 16'($urandom), 3'($urandom), 1'($urandom));
                else send_tick();
            end
        end
    endtask

    initial
    begin
        errors = 0;
        items_sent = 0;
        cmds_taken = 0;
        results_checked = 0;
        hold_asks = 0;
        gap_pct = 20;
        stall_pct = 20;
        rst_n = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.opcode = OP_TICK;
        cmd_ch.value = 16'h0000;
        cmd_ch.position = 3'd0;
        cmd_ch.flag = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_DATA_CMD;
        cfg_data = 8'h00;
        reset_predictor();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_commands();
        test_register_extremes();
        test_backpressure();
        test_random();

        run_until_idle();
        pause_sender();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_levels.size() != 0) errors++;

        $display("Sent %0d items (%0d commands taken), checked %0d results", items_sent,
                 cmds_taken, results_checked);
        $display("Covered every opcode, register extremes, stalls and random rounds");
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
